### rtl/core/sil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg
// shared types and codes for the sorted insert list and its cells
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int ENTRY_W = 32;
  localparam int INDEX_W = 4;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_RANGE     = 2'd3;

  // what the cells do this cycle
  typedef enum logic [1:0] {
    ACT_IDLE,
    ACT_CMP,
    ACT_INS,
    ACT_DEL
  } act_e;

  // which cell marks the insert or delete point
  typedef enum logic [1:0] {
    PICK_FRONT,
    PICK_TAIL,
    PICK_GAP,
    PICK_MATCH
  } pick_e;

  typedef struct packed {
    act_e                       act;
    pick_e                      pick;
    logic signed [ENTRY_W-1:0]  value;
  } cell_cmd_t;

  typedef struct packed {
    logic                       ge;
    logic                       tail_le;
    logic                       ord;
    logic [ENTRY_W-1:0]         rd;
  } cell_stat_t;

endpackage

### rtl/core/sil_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_in_if
// request channel of the sorted insert list: operation, value and index
// ----------------------------------------------------------------------------
interface sil_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] value;
  logic [3:0]         index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

### rtl/core/sil_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_out_if
// result channel of the sorted insert list
// ----------------------------------------------------------------------------
interface sil_out_if #(
  parameter int CNT_W = 5
);
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [CNT_W-1:0]   count;
  logic               is_ascending;
  logic [1:0]         status;

  modport source (output valid, output read_value, output count, output is_ascending,
                  output status, input ready);
  modport sink   (input valid, input read_value, input count, input is_ascending,
                  input status, output ready);
endinterface

### rtl/core/sorted_insert_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_list
// ordered list of up to DEPTH signed 32-bit entries built as a row of cells
// ----------------------------------------------------------------------------
// Items are handled one at a time, in three steps: in the accept cycle
// every cell compares its entry with the item value, in the update step
// the cells find the insert or delete point along the chain and shift in
// one step, and in the final step the order check over the new contents
// and the read select load the output register. A new item is taken in
// the cycle after that, so the block never takes a new item before it is
// through with the last one; a stalled result holds the final step.
// Entries never written are never read: a read at or past the count returns
// zero with the out-of-range status.
module sorted_insert_list
  import sil_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sil_in_if.sink        in_i,
  sil_out_if.source     out_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_vld_q, out_vld_d;

  // captured item
  logic [1:0]                op_q;
  logic signed [ENTRY_W-1:0] value_q;
  logic [INDEX_W-1:0]        index_q;

  // result of the update cycle
  logic [1:0]                status_q, status_d;
  logic                      read_ok_q, read_ok_d;

  // output register
  logic signed [ENTRY_W-1:0] rd_out_q;
  logic [CNT_W-1:0]          cnt_out_q;
  logic                      asc_out_q;
  logic [1:0]                stat_out_q;

  cell_cmd_t                 cmd;
  logic                      accept;
  logic                      full;
  logic                      found;
  logic                      tail_le;
  logic                      asc;
  logic [ENTRY_W-1:0]        rd_any;

  // chain wiring between neighbors
  logic signed [ENTRY_W-1:0] entry_w [DEPTH];
  logic                      le_w    [DEPTH];
  logic                      pfx_w   [DEPTH];
  cell_stat_t                stat_w  [DEPTH];

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign found      = pfx_w[DEPTH-1];

  // or of the per-cell flags, and of the per-cell order bits
  always_comb begin
    tail_le = 1'b0;
    asc     = 1'b1;
    rd_any  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tail_le = tail_le | stat_w[k].tail_le;
      asc     = asc & stat_w[k].ord;
      rd_any  = rd_any | stat_w[k].rd;
    end
  end

  // command to the cells and the sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    out_vld_d = out_vld_q;
    status_d  = status_q;
    read_ok_d = read_ok_q;
    cmd.act   = ACT_IDLE;
    cmd.pick  = PICK_MATCH;
    cmd.value = value_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        // compare every entry with the incoming value
        cmd.value = in_i.value;
        if (accept) begin
          cmd.act = ACT_CMP;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        status_d  = STAT_OK;
        read_ok_d = 1'b0;
        unique case (op_q) inside
          OP_INSERT, OP_APPEND: begin
            // pick the insert point: front, tail or first gap
            if (op_q == OP_APPEND || count_q == '0) begin
              cmd.pick = PICK_TAIL;
            end else if (stat_w[0].ge) begin
              cmd.pick = PICK_FRONT;
            end else if (tail_le) begin
              cmd.pick = PICK_TAIL;
            end else begin
              cmd.pick = PICK_GAP;
            end
            if (full) begin
              status_d = STAT_FULL;
            end else begin
              cmd.act = ACT_INS;
              count_d = count_q + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            cmd.pick = PICK_MATCH;
            cmd.act  = ACT_DEL;
            if (found) begin
              count_d = count_q - CNT_W'(1);
            end else begin
              status_d = STAT_NOT_FOUND;
            end
          end
          OP_READ: begin
            if (int'(index_q) < int'(count_q)) begin
              read_ok_d = 1'b1;
            end else begin
              status_d = STAT_RANGE;
            end
          end
          default: begin
          end
        endcase
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // load the result once the output register is free
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // row of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [ENTRY_W-1:0] prev_entry;
    logic                      prev_le;
    logic                      prev_pfx;
    logic signed [ENTRY_W-1:0] next_entry;

    if (k == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_le    = 1'b0;
      assign prev_pfx   = 1'b0;
    end else begin : g_body
      assign prev_entry = entry_w[k-1];
      assign prev_le    = le_w[k-1];
      assign prev_pfx   = pfx_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign next_entry = entry_w[k];
    end else begin : g_inner
      assign next_entry = entry_w[k+1];
    end

    sil_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .index_i      (index_q),
      .prev_entry_i (prev_entry),
      .prev_le_i    (prev_le),
      .prefix_i     (prev_pfx),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[k]),
      .le_o         (le_w[k]),
      .prefix_o     (pfx_w[k]),
      .stat_o       (stat_w[k])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.op;
      value_q <= in_i.value;
      index_q <= in_i.index;
    end
    status_q  <= status_d;
    read_ok_q <= read_ok_d;
    if (state_q == ST_FIN && (!out_vld_q || out_o.ready)) begin
      rd_out_q   <= read_ok_q ? rd_any : '0;
      cnt_out_q  <= count_q;
      asc_out_q  <= asc;
      stat_out_q <= status_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.read_value   = rd_out_q;
  assign out_o.count        = cnt_out_q;
  assign out_o.is_ascending = asc_out_q;
  assign out_o.status       = stat_out_q;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= DEPTH)
    else $error("count above depth");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted item did not reach update cycle");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && full && (op_q == OP_INSERT || op_q == OP_APPEND))
    |=> count_q == $past(count_q))
    else $error("count changed on a dropped insert");

  a_del_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && op_q == OP_DELETE && found)
    |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("delete hit did not shrink the list");

  a_fin_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_vld_q || out_o.ready))
    |=> out_vld_q && out_o.count == $past(count_q))
    else $error("result count does not match list");
`endif

endmodule

### rtl/core/sil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_cell
// one list slot: holds an entry, compares it with the item value and shifts
// toward its neighbors on insert and delete
// ----------------------------------------------------------------------------
module sil_cell
  import sil_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                      clk_i,
  input  cell_cmd_t                 cmd_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic [INDEX_W-1:0]        index_i,
  input  logic signed [ENTRY_W-1:0] prev_entry_i,
  input  logic                      prev_le_i,
  input  logic                      prefix_i,
  input  logic signed [ENTRY_W-1:0] next_entry_i,
  output logic signed [ENTRY_W-1:0] entry_o,
  output logic                      le_o,
  output logic                      prefix_o,
  output cell_stat_t                stat_o
);

  logic signed [ENTRY_W-1:0] entry_q, entry_d;
  logic                      le_q, le_d;
  logic                      ge_q, ge_d;
  logic                      occ;
  logic                      mark;

  assign occ = (CNT_W'(IDX) < count_i);

  always_comb begin
    case (cmd_i.pick)
      PICK_FRONT: mark = (IDX == 0);
      PICK_TAIL:  mark = (CNT_W'(IDX) == count_i);
      PICK_GAP:   mark = (IDX != 0) && prev_le_i && ge_q && occ;
      PICK_MATCH: mark = le_q && ge_q && occ;
      default:    mark = 1'b0;
    endcase
  end

  // set once the insert or delete point lies at or left of this cell
  assign prefix_o = prefix_i | mark;

  always_comb begin
    entry_d = entry_q;
    le_d    = le_q;
    ge_d    = ge_q;
    case (cmd_i.act)
      ACT_CMP: begin
        le_d = (entry_q <= cmd_i.value);
        ge_d = (entry_q >= cmd_i.value);
      end
      ACT_INS: begin
        if (prefix_i) begin
          entry_d = prev_entry_i;
        end else if (mark) begin
          entry_d = cmd_i.value;
        end
      end
      ACT_DEL: begin
        if (prefix_o) begin
          entry_d = next_entry_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    le_q    <= le_d;
    ge_q    <= ge_d;
  end

  assign entry_o        = entry_q;
  assign le_o           = le_q;
  assign stat_o.ge      = ge_q;
  assign stat_o.tail_le = le_q && (CNT_W'(IDX + 1) == count_i);
  assign stat_o.ord     = (IDX == 0) || !occ || (prev_entry_i <= entry_q);
  assign stat_o.rd      = (int'(index_i) == IDX) ? entry_q : '0;

endmodule

### sim/sil_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_result_checker
// watches both channels of the sorted insert list, keeps a shadow copy of the
// list, predicts each result and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module sil_result_checker
  import sil_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  sil_in_if    in_mon,
  sil_out_if   out_mon,
  output int   pending_o,
  output int   mismatch_cnt_o
);

  typedef struct packed {
    logic signed [ENTRY_W-1:0] read_value;
    logic [CNT_W-1:0]          count;
    logic                      ascending;
    logic [1:0]                status;
  } list_result_t;

  logic signed [ENTRY_W-1:0] shadow_entries [DEPTH];
  int                        shadow_count;
  list_result_t              expected_results [$];
  list_result_t              want;
  list_result_t              got;

  initial mismatch_cnt_o = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] sorted list mismatch: %s", $time, what);
    mismatch_cnt_o++;
  endtask

  // apply one operation to the shadow list and return the result it gives
  function automatic list_result_t apply_list_op(input logic [1:0] op,
                                                 input logic signed [ENTRY_W-1:0] v,
                                                 input logic [INDEX_W-1:0] idx);
    list_result_t r;
    int           pos;
    int           hit;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pos = shadow_count;
          if (op == OP_INSERT && shadow_count != 0) begin
            if (shadow_entries[0] >= v) begin
              pos = 0;
            end else if (shadow_entries[shadow_count-1] > v) begin
              // first gap that brackets the value
              for (int k = 0; k + 1 < shadow_count; k++) begin
                if (shadow_entries[k] <= v && v <= shadow_entries[k+1]) begin
                  pos = k + 1;
                  break;
                end
              end
            end
          end
          for (int k = shadow_count; k > pos; k--)
            shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[pos] = v;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        hit = -1;
        for (int k = 0; k < shadow_count; k++) begin
          if (shadow_entries[k] == v) begin
            hit = k;
            break;
          end
        end
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          for (int k = hit; k + 1 < shadow_count; k++)
            shadow_entries[k] = shadow_entries[k+1];
          shadow_count--;
        end
      end
      default: begin
        if (int'(idx) < shadow_count) r.read_value = shadow_entries[idx];
        else r.status = STAT_RANGE;
      end
    endcase
    r.count = CNT_W'(shadow_count);
    r.ascending = 1'b1;
    for (int k = 1; k < shadow_count; k++)
      if (shadow_entries[k] < shadow_entries[k-1]) r.ascending = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      for (int k = 0; k < DEPTH; k++) shadow_entries[k] = '0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(apply_list_op(in_mon.op, in_mon.value, in_mon.index));
      if (out_mon.valid && out_mon.ready) begin
        got.read_value = out_mon.read_value;
        got.count      = out_mon.count;
        got.ascending  = out_mon.is_ascending;
        got.status     = out_mon.status;
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      got.read_value, want.read_value));
          if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
          if (got.ascending !== want.ascending)
            report_mismatch($sformatf("is_ascending %b, expected %b",
                                      got.ascending, want.ascending));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

### sim/sorted_insert_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_list_tb
// stimulus and verdict for the sorted insert list
// ----------------------------------------------------------------------------
// A directed run walks the edge cases (empty list, front, tail and gap
// inserts, equal values, extreme values, an unsorted list from appends,
// first-match delete, missing delete, out of range reads, full list drops),
// then three random phases follow with different idling on both sides. The
// random items alternate between growing and shrinking stretches so the list
// swings between empty and full. A side checker predicts every result.
// ----------------------------------------------------------------------------
module sorted_insert_list_tb;
  import sil_pkg::*;

  localparam int DEPTH         = 16;
  localparam int CNT_W         = 5;
  localparam int PHASE_ITEMS   = 460;
  localparam int STRETCH_ITEMS = 40;
  localparam int HOLD_LEN      = 80;
  localparam int DRAIN_CYCLES  = 10;
  localparam int STALL_LIMIT   = 2000;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk_i;
  logic rst_ni;

  // idling chances in percent, changed per phase
  int send_idle_pct;
  int recv_stall_pct;

  // long receiver hold-off: the main process bumps the request count,
  // the receiver process notices and counts the stretch itself
  int hold_reqs;
  int hold_seen;
  int hold_left;

  int pending_results;
  int mismatches;

  sil_in_if                   in_ch ();
  sil_out_if #(.CNT_W(CNT_W)) out_ch ();

  sorted_insert_list #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sil_result_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .pending_o      (pending_results),
    .mismatch_cnt_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: ready changes on the falling edge only
  initial begin
    out_ch.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: too many cycles in a row with no item moving on either side
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck = 0;
      else stuck++;
    end
    $display("[sorted_insert_list] ERROR");
    $finish;
  end

  // offer one item; called and returns on a falling edge, valid stays high
  // unless the sender decides to idle before this item
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] val,
                           input logic [3:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      // junk on the payload while valid is low
      in_ch.op    <= 2'($urandom);
      in_ch.value <= $urandom;
      in_ch.index <= 4'($urandom);
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= val;
    in_ch.index <= idx;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random item; growing stretches favor inserts, shrinking ones deletes
  task automatic random_item(input bit grow);
    logic [1:0]         op;
    logic signed [31:0] val;
    int                 pick;
    pick = $urandom_range(99);
    if (grow)
      op = (pick < 50) ? OP_INSERT : (pick < 65) ? OP_APPEND :
           (pick < 80) ? OP_DELETE : OP_READ;
    else
      op = (pick < 10) ? OP_INSERT : (pick < 15) ? OP_APPEND :
           (pick < 80) ? OP_DELETE : OP_READ;
    // a small pool of values makes equal entries and delete hits common
    pick = $urandom_range(99);
    if (pick < 55) begin
      val = $urandom_range(16);
      val = val - 8;
    end else if (pick < 70) begin
      case ($urandom_range(5))
        0:       val = VAL_MIN;
        1:       val = VAL_MAX;
        2:       val = VAL_MIN + 1;
        3:       val = VAL_MAX - 1;
        4:       val = -1;
        default: val = 0;
      endcase
    end else begin
      val = $urandom;
    end
    send_item(op, val, 4'($urandom_range(15)));
  endtask

  initial begin
    int n;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_INSERT;
    in_ch.value    = '0;
    in_ch.index    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty list cases
    send_item(OP_READ,   0,  4'd0);         // read on empty list
    send_item(OP_DELETE, 5,  4'd0);         // delete with no match
    send_item(OP_INSERT, 0,  4'd0);         // insert into empty list
    send_item(OP_INSERT, VAL_MIN, 4'd0);    // front
    send_item(OP_INSERT, VAL_MAX, 4'd0);    // tail
    send_item(OP_INSERT, 0,  4'd0);         // equal value lands in the first gap
    send_item(OP_INSERT, -5, 4'd0);         // gap
    send_item(OP_APPEND, -7, 4'd0);         // list no longer ascending
    send_item(OP_INSERT, 3,  4'd0);         // ordered insert on unsorted list
    send_item(OP_READ,   0,  4'd0);
    send_item(OP_READ,   0,  4'd15);        // past the count
    send_item(OP_DELETE, 0,  4'd0);         // first of two equal entries
    send_item(OP_DELETE, VAL_MAX, 4'd0);
    // fill up, then hit the full list with both kinds of insert
    for (n = 0; n < 11; n++) send_item(OP_APPEND, $urandom, 4'd0);
    send_item(OP_INSERT, 1, 4'd0);
    send_item(OP_APPEND, 2, 4'd0);
    send_item(OP_READ,   0, 4'd15);         // last slot of a full list

    for (int ph = 0; ph < 3; ph++) begin
      // sender pauses until every result is back
      in_ch.valid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clk_i);
      case (ph)
        0: begin
          send_idle_pct  <= 16;
          recv_stall_pct <= 69;
        end
        1: begin
          send_idle_pct  <= 69;
          recv_stall_pct <= 16;
        end
        default: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while items keep coming, fills the pipe
        if (ph != 1 && n == 20) hold_reqs <= hold_reqs + 1;
        random_item(((n / STRETCH_ITEMS) % 2) == 0);
      end
    end

    in_ch.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[sorted_insert_list] OK");
    end else begin
      $display("[sorted_insert_list] ERROR");
    end
    $finish;
  end

endmodule

### sorted_insert_list.f
rtl/core/sil_pkg.sv
rtl/core/sil_in_if.sv
rtl/core/sil_out_if.sv
rtl/core/sil_cell.sv
rtl/core/sorted_insert_list.sv
sim/sil_result_checker.sv
sim/sorted_insert_list_tb.sv
